@@ rtl/core/qrs_pkg.sv @@
`timescale 1ns / 1ps
package qrs_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_LIN  = 2'd1;
  localparam kind_t KIND_ONE  = 2'd2;
  localparam kind_t KIND_TWO  = 2'd3;

  localparam int ROOT_W = 32;

endpackage

@@ rtl/core/qrs_fifo.sv @@
`timescale 1ns / 1ps
module qrs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         ready,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push_ok;
  logic          pop_ok;

  assign empty   = (count == '0);
  assign pop_ok  = pop && !empty;
  assign ready   = (count != CW'(DEPTH)) || pop_ok;
  assign push_ok = push && ready;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop_ok) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (!push_ok && pop_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wptr] <= din;
    end
  end

endmodule

@@ rtl/core/qrs_front.sv @@
`timescale 1ns / 1ps
module qrs_front #(
  parameter int CW = 16,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] coef_a,
  input  logic signed [CW-1:0] coef_b,
  input  logic signed [CW-1:0] coef_c,
  output logic                 out_vld,
  output logic [2+(CW+F+1)+(CW+1)+(2*CW+1)-1:0] item
);
  import qrs_pkg::*;

  localparam int NBW = CW + F + 1;
  localparam int DNW = CW + 1;
  localparam int DW  = 2 * CW + 1;
  localparam int XW  = 2 * CW + 2;

  logic                 vld1;
  logic signed [CW-1:0] a1, b1, c1;
  logic [2*CW-1:0]      bb1, ac1;

  logic [CW-1:0]         ma, mb, mc;
  logic [XW-1:0]         b2x, ac4, dsum, ddiff;
  logic                  ac_neg;
  logic signed [NBW-1:0] bx, cx, nb;
  logic signed [DNW-1:0] den;
  logic [DW-1:0]         d;
  kind_t                 kind;

  function automatic logic [CW-1:0] a1_abs(input logic signed [CW-1:0] v);
    a1_abs = v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  assign ma = a1_abs(coef_a);
  assign mb = a1_abs(coef_b);
  assign mc = a1_abs(coef_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= coef_a;
      b1  <= coef_b;
      c1  <= coef_c;
      bb1 <= mb * mb;
      ac1 <= ma * mc;
    end
  end

  always_comb begin
    b2x    = XW'(bb1);
    ac4    = {ac1, 2'b00};
    dsum   = b2x + ac4;
    ddiff  = b2x - ac4;
    ac_neg = (a1[CW-1] != c1[CW-1]) && (c1 != '0);
    bx     = NBW'(b1);
    cx     = NBW'(c1);
    d      = '0;
    if (a1 == '0) begin
      kind = (b1 != '0) ? KIND_LIN : KIND_NONE;
      nb   = (-cx) <<< F;
      den  = DNW'(b1);
    end else begin
      nb  = (-bx) <<< F;
      den = $signed({a1, 1'b0});
      if (ac_neg) begin
        kind = KIND_TWO;
        d    = dsum[DW-1:0];
      end else if (b2x > ac4) begin
        kind = KIND_TWO;
        d    = ddiff[DW-1:0];
      end else if (b2x == ac4) begin
        kind = KIND_ONE;
      end else begin
        kind = KIND_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= {kind, nb, den, d};
    end
  end

endmodule

@@ rtl/core/qrs_sqrt.sv @@
`timescale 1ns / 1ps
module qrs_sqrt #(
  parameter int SW = 33,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*SW-1:0] rad,
  input  logic [TW-1:0]   tag_in,
  output logic            out_vld,
  output logic [SW-1:0]   root,
  output logic [TW-1:0]   tag_out
);
  localparam int RW = SW + 3;

  logic [RW-1:0]   rem_q  [SW];
  logic [SW-1:0]   root_q [SW];
  logic [2*SW-1:0] rad_q  [SW];
  logic [TW-1:0]   tag_q  [SW];
  logic [SW-1:0]   vld_q;

  logic [RW-1:0]   in_rem  [SW];
  logic [SW-1:0]   in_root [SW];
  logic [2*SW-1:0] in_rad  [SW];
  logic [TW-1:0]   in_tag  [SW];
  logic [RW-1:0]   sh      [SW];
  logic [RW-1:0]   trial   [SW];
  logic [RW-1:0]   rem_d   [SW];
  logic [SW-1:0]   root_d  [SW];
  logic [SW-1:0]   ge;

  always_comb begin
    in_rem[0]  = '0;
    in_root[0] = '0;
    in_rad[0]  = rad;
    in_tag[0]  = tag_in;
    for (int k = 1; k < SW; k++) begin
      in_rem[k]  = rem_q[k-1];
      in_root[k] = root_q[k-1];
      in_rad[k]  = rad_q[k-1];
      in_tag[k]  = tag_q[k-1];
    end
    for (int k = 0; k < SW; k++) begin
      sh[k]     = {in_rem[k][RW-3:0], in_rad[k][2*(SW-1-k) +: 2]};
      trial[k]  = {1'b0, in_root[k], 2'b01};
      ge[k]     = (sh[k] >= trial[k]);
      rem_d[k]  = ge[k] ? sh[k] - trial[k] : sh[k];
      root_d[k] = {in_root[k][SW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[SW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SW; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= in_rad[k];
        tag_q[k]  <= in_tag[k];
      end
    end
  end

  assign out_vld = vld_q[SW-1];
  assign root    = root_q[SW-1];
  assign tag_out = tag_q[SW-1];

endmodule

@@ rtl/core/qrs_div.sv @@
`timescale 1ns / 1ps
module qrs_div #(
  parameter int NW  = 33,
  parameter int DVW = 17,
  parameter int TW  = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  num0,
  input  logic [NW-1:0]  num1,
  input  logic [DVW-1:0] den,
  input  logic [TW-1:0]  tag_in,
  output logic           out_vld,
  output logic [NW-1:0]  quo0,
  output logic [NW-1:0]  quo1,
  output logic [TW-1:0]  tag_out
);
  localparam int RW = DVW + 1;

  logic [NW-1:0]  n0_q [NW];
  logic [NW-1:0]  n1_q [NW];
  logic [RW-1:0]  r0_q [NW];
  logic [RW-1:0]  r1_q [NW];
  logic [NW-1:0]  q0_q [NW];
  logic [NW-1:0]  q1_q [NW];
  logic [DVW-1:0] dn_q [NW];
  logic [TW-1:0]  tg_q [NW];
  logic [NW-1:0]  vld_q;

  logic [NW-1:0]  in_n0 [NW];
  logic [NW-1:0]  in_n1 [NW];
  logic [RW-1:0]  in_r0 [NW];
  logic [RW-1:0]  in_r1 [NW];
  logic [NW-1:0]  in_q0 [NW];
  logic [NW-1:0]  in_q1 [NW];
  logic [DVW-1:0] in_dn [NW];
  logic [TW-1:0]  in_tg [NW];
  logic [RW-1:0]  sh0   [NW];
  logic [RW-1:0]  sh1   [NW];
  logic [RW-1:0]  dd    [NW];
  logic [RW-1:0]  r0_d  [NW];
  logic [RW-1:0]  r1_d  [NW];
  logic [NW-1:0]  ge0, ge1;

  always_comb begin
    in_n0[0] = num0;
    in_n1[0] = num1;
    in_r0[0] = '0;
    in_r1[0] = '0;
    in_q0[0] = '0;
    in_q1[0] = '0;
    in_dn[0] = den;
    in_tg[0] = tag_in;
    for (int k = 1; k < NW; k++) begin
      in_n0[k] = n0_q[k-1];
      in_n1[k] = n1_q[k-1];
      in_r0[k] = r0_q[k-1];
      in_r1[k] = r1_q[k-1];
      in_q0[k] = q0_q[k-1];
      in_q1[k] = q1_q[k-1];
      in_dn[k] = dn_q[k-1];
      in_tg[k] = tg_q[k-1];
    end
    for (int k = 0; k < NW; k++) begin
      dd[k]   = {1'b0, in_dn[k]};
      sh0[k]  = {in_r0[k][DVW-1:0], in_n0[k][NW-1-k]};
      sh1[k]  = {in_r1[k][DVW-1:0], in_n1[k][NW-1-k]};
      ge0[k]  = (sh0[k] >= dd[k]);
      ge1[k]  = (sh1[k] >= dd[k]);
      r0_d[k] = ge0[k] ? sh0[k] - dd[k] : sh0[k];
      r1_d[k] = ge1[k] ? sh1[k] - dd[k] : sh1[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        n0_q[k] <= in_n0[k];
        n1_q[k] <= in_n1[k];
        r0_q[k] <= r0_d[k];
        r1_q[k] <= r1_d[k];
        q0_q[k] <= {in_q0[k][NW-2:0], ge0[k]};
        q1_q[k] <= {in_q1[k][NW-2:0], ge1[k]};
        dn_q[k] <= in_dn[k];
        tg_q[k] <= in_tg[k];
      end
    end
  end

  assign out_vld = vld_q[NW-1];
  assign quo0    = q0_q[NW-1];
  assign quo1    = q1_q[NW-1];
  assign tag_out = tg_q[NW-1];

endmodule

@@ rtl/core/qrs_back.sv @@
`timescale 1ns / 1ps
module qrs_back #(
  parameter int CW = 16,
  parameter int F  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic item_vld,
  input  logic [2+(CW+F+1)+(CW+1)+(2*CW+1)-1:0] item,
  output logic res_vld,
  output logic [2+2*qrs_pkg::ROOT_W:0] res
);
  import qrs_pkg::*;

  localparam int NBW  = CW + F + 1;
  localparam int DNW  = CW + 1;
  localparam int DW   = 2 * CW + 1;
  localparam int SW   = CW + F + 1;
  localparam int NW   = CW + F + 1;
  localparam int NUMW = CW + F + 2;
  localparam int DVW  = CW + 1;
  localparam int TW1  = 2 + NBW + DNW;
  localparam int QX   = (NW > ROOT_W + 1) ? NW : ROOT_W + 1;

  logic [DW-1:0]   d;
  logic [TW1-1:0]  tag1;
  logic            s_vld;
  logic [SW-1:0]   s;
  logic [TW1-1:0]  s_tag;

  kind_t                  s_kind;
  logic signed [NBW-1:0]  s_nb;
  logic signed [DNW-1:0]  s_den;
  logic signed [NUMW-1:0] nbe, se, n1, n2;

  logic            m_vld;
  logic [NW-1:0]   m_n1, m_n2;
  logic [DVW-1:0]  m_den;
  logic [3:0]      m_tag;

  logic            q_vld;
  logic [NW-1:0]   q1, q2;
  logic [3:0]      q_tag;
  kind_t           q_kind;
  logic            neg1, neg2, sat1, sat2;
  logic [QX-1:0]   q1x, q2x;
  logic [ROOT_W-1:0] r1, r2;
  logic [1:0]      cnt;
  logic            sat;

  assign d    = item[DW-1:0];
  assign tag1 = item[DW +: TW1];

  qrs_sqrt #(.SW(SW), .TW(TW1)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (item_vld),
    .rad     ((2*SW)'(d) << (2*F)),
    .tag_in  (tag1),
    .out_vld (s_vld),
    .root    (s),
    .tag_out (s_tag)
  );

  always_comb begin
    s_kind = s_tag[TW1-1 -: 2];
    s_nb   = $signed(s_tag[DNW +: NBW]);
    s_den  = $signed(s_tag[DNW-1:0]);
    nbe    = NUMW'(s_nb);
    se     = $signed(NUMW'(s));
    n1     = nbe + se;
    n2     = nbe - se;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_n1  <= n1[NUMW-1] ? NW'(-n1) : NW'(n1);
      m_n2  <= n2[NUMW-1] ? NW'(-n2) : NW'(n2);
      m_den <= s_den[DNW-1] ? DVW'(-s_den) : DVW'(s_den);
      m_tag <= {s_kind, n1[NUMW-1] ^ s_den[DNW-1], n2[NUMW-1] ^ s_den[DNW-1]};
    end
  end

  qrs_div #(.NW(NW), .DVW(DVW), .TW(4)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (m_vld),
    .num0    (m_n1),
    .num1    (m_n2),
    .den     (m_den),
    .tag_in  (m_tag),
    .out_vld (q_vld),
    .quo0    (q1),
    .quo1    (q2),
    .tag_out (q_tag)
  );

  always_comb begin
    q_kind = q_tag[3:2];
    neg1   = q_tag[1];
    neg2   = q_tag[0];
    q1x    = QX'(q1);
    q2x    = QX'(q2);
    if (neg1) begin
      sat1 = q1x > QX'(64'h8000_0000);
      r1   = sat1 ? 32'h8000_0000 : ROOT_W'(-q1x);
    end else begin
      sat1 = q1x > QX'(64'h7fff_ffff);
      r1   = sat1 ? 32'h7fff_ffff : ROOT_W'(q1x);
    end
    if (neg2) begin
      sat2 = q2x > QX'(64'h8000_0000);
      r2   = sat2 ? 32'h8000_0000 : ROOT_W'(-q2x);
    end else begin
      sat2 = q2x > QX'(64'h7fff_ffff);
      r2   = sat2 ? 32'h7fff_ffff : ROOT_W'(q2x);
    end
    cnt = 2'd0;
    sat = 1'b0;
    case (q_kind)
      KIND_LIN, KIND_ONE: begin
        cnt = 2'd1;
        r2  = '0;
        sat = sat1;
      end
      KIND_TWO: begin
        cnt = 2'd2;
        sat = sat1 | sat2;
      end
      default: begin
        r1 = '0;
        r2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (en) begin
      res_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= {cnt, r1, r2, sat};
    end
  end

endmodule

@@ rtl/core/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
// channel   handshake        fields
// input     push / full      coef_a, coef_b, coef_c
// result    pop / empty      root_count, root_first, root_second, saturated
//
// One item per cycle sustained while full stays low; each result passes through
// the digit-per-stage square root and the bit-per-stage divider.
// Reset (rst, synchronous) empties both queues and clears all stage valids.
// The front stalls only when the middle queue is full; the back stalls only
// when the result queue is full and not popped.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COEF_WIDTH-1:0] coef_a,
  input  logic signed [COEF_WIDTH-1:0] coef_b,
  input  logic signed [COEF_WIDTH-1:0] coef_c,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   root_count,
  output logic signed [qrs_pkg::ROOT_W-1:0] root_first,
  output logic signed [qrs_pkg::ROOT_W-1:0] root_second,
  output logic                         saturated
);
  import qrs_pkg::*;

  localparam int ITEMW = 2 + (COEF_WIDTH + FRAC_BITS + 1) + (COEF_WIDTH + 1)
                         + (2 * COEF_WIDTH + 1);
  localparam int RESW  = 3 + 2 * ROOT_W;

  logic             en_f, en_b;
  logic             f_vld;
  logic [ITEMW-1:0] f_item;
  logic [ITEMW-1:0] m_item;
  logic             m_empty;
  logic             r_vld;
  logic [RESW-1:0]  r_data;
  logic [RESW-1:0]  o_data;

  assign full = !en_f;

  qrs_front #(.CW(COEF_WIDTH), .F(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en_f),
    .in_vld  (push),
    .coef_a  (coef_a),
    .coef_b  (coef_b),
    .coef_c  (coef_c),
    .out_vld (f_vld),
    .item    (f_item)
  );

  qrs_fifo #(.W(ITEMW), .DEPTH(4)) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (f_vld),
    .din   (f_item),
    .ready (en_f),
    .pop   (en_b),
    .dout  (m_item),
    .empty (m_empty)
  );

  qrs_back #(.CW(COEF_WIDTH), .F(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en_b),
    .item_vld (!m_empty),
    .item     (m_item),
    .res_vld  (r_vld),
    .res      (r_data)
  );

  qrs_fifo #(.W(RESW), .DEPTH(2)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (r_vld),
    .din   (r_data),
    .ready (en_b),
    .pop   (pop),
    .dout  (o_data),
    .empty (empty)
  );

  assign root_count  = o_data[RESW-1 -: 2];
  assign root_first  = $signed(o_data[ROOT_W+1 +: ROOT_W]);
  assign root_second = $signed(o_data[1 +: ROOT_W]);
  assign saturated   = o_data[0];

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> root_count != 2'd3)
    else $error("root count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && root_count == 2'd0) |-> (root_first == '0 && root_second == '0 && !saturated))
    else $error("no-root item carries nonzero fields");

  a_one_second_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && root_count == 2'd1) |-> root_second == '0)
    else $error("single-root item has second root");

  a_sat_implies_root: assert property (@(posedge clk) disable iff (rst)
    (!empty && saturated) |-> root_count != 2'd0)
    else $error("saturation flagged without a root");

endmodule
